@@ hw/rtl/etm_pkg.sv @@
`timescale 1ns / 1ps
package etm_pkg;

    // pipeline depths of the back end
    localparam int SQ_STEPS = 32;   // one result bit per stage, 64-bit radicand
    localparam int SC_STEPS = 51;   // scaled-vector quotient bits
    localparam int QD_STEPS = 34;   // Q16.16 entry quotient bits
    localparam int BACK_DEPTH = (SQ_STEPS + 1) + 1 + (SC_STEPS + 1) + 1 + 1 + (QD_STEPS + 1) + 1;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BOUNDARY = 2'd1;
    localparam logic [1:0] ST_DEGEN    = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

    // barycentric corner vectors, code 3 maps to nothing
    localparam logic [3:0] CORNER_X = 4'b0010;
    localparam logic [3:0] CORNER_Y = 4'b0100;

    localparam logic [50:0] X_CLAMP = 51'd1 << 50;

    typedef struct packed {
        logic signed [31:0] first_m11;
        logic signed [31:0] first_m12;
        logic signed [31:0] first_m22;
        logic signed [31:0] second_m11;
        logic signed [31:0] second_m12;
        logic signed [31:0] second_m22;
        logic [1:0]         first_tail_corner;
        logic [1:0]         first_head_corner;
        logic [1:0]         second_tail_corner;
        logic [1:0]         second_head_corner;
        logic               on_boundary;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] fwd_t11;
        logic signed [31:0] fwd_t12;
        logic signed [31:0] fwd_t21;
        logic signed [31:0] fwd_t22;
        logic signed [31:0] back_t11;
        logic signed [31:0] back_t12;
        logic signed [31:0] back_t21;
        logic signed [31:0] back_t22;
        logic [1:0]         status;
    } t_out_word;

    typedef struct packed {
        logic signed [1:0] e1;
        logic signed [1:0] e2;
    } t_evec;

    typedef struct packed {
        logic signed [1:0]  e1;
        logic signed [1:0]  e2;
        logic signed [33:0] p1;
        logic signed [33:0] p2;
        logic signed [34:0] d;
    } t_face;

    typedef struct packed {
        t_face f1;
        t_face f2;
        logic  boundary;
        logic  bad;
    } t_carry;

    typedef struct packed {
        t_carry      c;
        logic [63:0] det1;
        logic [63:0] det2;
    } t_cls;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
    } t_sq;

    typedef struct packed {
        logic        q;
        logic [33:0] rem;
    } t_dstep;

    typedef struct packed {
        logic [33:0] rem;
        logic [50:0] word;
        logic        ovf;
        logic        neg;
    } t_sc_lane;

    typedef struct packed {
        logic [33:0] rem;
        logic [33:0] word;
        logic        ovf;
        logic        neg;
    } t_qd_lane;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } t_qres;

    function automatic t_evec face_edge(input logic [1:0] t, input logic [1:0] h);
        t_evec r;
        logic  hx;
        logic  hy;
        hx = CORNER_X[h] && (h != t);
        hy = CORNER_Y[h] && (h != t);
        r.e1 = $signed({1'b0, hx}) - $signed({1'b0, CORNER_X[t]});
        r.e2 = $signed({1'b0, hy}) - $signed({1'b0, CORNER_Y[t]});
        return r;
    endfunction

    // e is -1, 0 or 1
    function automatic logic signed [52:0] emul(input logic signed [1:0] e,
                                                input logic signed [52:0] v);
        logic signed [52:0] r;
        if (e == 2'sb01) begin
            r = v;
        end else if (e == 2'sb11) begin
            r = -v;
        end else begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic [32:0] pmag(input logic signed [33:0] p);
        logic [33:0] n;
        n = -p;
        return p[33] ? n[32:0] : p[32:0];
    endfunction

    function automatic t_sq sqrt_step(input t_sq s, input int k);
        logic [63:0] b;
        logic [63:0] tr;
        t_sq         r;
        b  = 64'd1 << (62 - 2 * k);
        tr = s.res + b;
        if (s.v >= tr) begin
            r.v   = s.v - tr;
            r.res = (s.res >> 1) + b;
        end else begin
            r.v   = s.v;
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    function automatic t_dstep div_step(input logic [33:0] rem, input logic din,
                                        input logic [33:0] dv);
        logic [34:0] tr;
        logic [34:0] df;
        t_dstep      r;
        tr = {rem, din};
        df = tr - {1'b0, dv};
        if (tr >= {1'b0, dv}) begin
            r.q   = 1'b1;
            r.rem = df[33:0];
        end else begin
            r.q   = 1'b0;
            r.rem = tr[33:0];
        end
        return r;
    endfunction

    function automatic t_sc_lane sc_next(input t_sc_lane l, input logic [33:0] dv);
        t_dstep   s;
        t_sc_lane r;
        s      = div_step(l.rem, l.word[50], dv);
        r      = l;
        r.rem  = s.rem;
        r.word = {l.word[49:0], s.q};
        return r;
    endfunction

    function automatic t_qd_lane qd_next(input t_qd_lane l, input logic [33:0] dv);
        t_dstep   s;
        t_qd_lane r;
        s      = div_step(l.rem, l.word[33], dv);
        r      = l;
        r.rem  = s.rem;
        r.word = {l.word[32:0], s.q};
        return r;
    endfunction

    function automatic logic signed [51:0] x_of(input t_sc_lane l);
        logic [50:0]        m;
        logic signed [51:0] x;
        if (l.ovf || (l.word > X_CLAMP)) begin
            m = X_CLAMP;
        end else begin
            m = l.word;
        end
        x = $signed({1'b0, m});
        return l.neg ? -x : x;
    endfunction

    function automatic t_qres q_final(input t_qd_lane l);
        t_qres       r;
        logic [33:0] n;
        n = -l.word;
        if (l.neg) begin
            if (l.ovf || (l.word > 34'h080000000)) begin
                r.sat = 1'b1;
                r.val = 32'h80000000;
            end else begin
                r.sat = 1'b0;
                r.val = n[31:0];
            end
        end else begin
            if (l.ovf || (l.word > 34'h07FFFFFFF)) begin
                r.sat = 1'b1;
                r.val = 32'h7FFFFFFF;
            end else begin
                r.sat = 1'b0;
                r.val = l.word[31:0];
            end
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/etm_in_if.sv @@
`timescale 1ns / 1ps
interface etm_in_if;
    import etm_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/etm_out_if.sv @@
`timescale 1ns / 1ps
interface etm_out_if;
    import etm_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/etm_front.sv @@
`timescale 1ns / 1ps
module etm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    etm_in_if.sink        i_edge,
    output etm_pkg::t_cls o_cls,
    output logic          o_cls_valid,
    input  logic          i_cls_ready
);
    import etm_pkg::*;

    typedef struct packed {
        t_face       f;
        logic [63:0] det;
        logic        bad;
    } t_fcalc;

    logic               en;
    logic               r_v1;
    logic               r_v2;
    logic signed [31:0] r_a11, r_a12, r_a22, r_b11, r_b12, r_b22;
    logic signed [63:0] r_pa1, r_pb1, r_pa2, r_pb2;
    t_evec              r_ea, r_eb;
    logic               r_bnd;
    t_cls               r_cls;
    t_evec              ea, eb;
    t_fcalc             fa, fb;

    function automatic t_fcalc face_calc(input logic signed [31:0] m11,
                                         input logic signed [31:0] m12,
                                         input logic signed [31:0] m22,
                                         input t_evec e,
                                         input logic signed [63:0] pa,
                                         input logic signed [63:0] pb);
        t_fcalc             r;
        logic signed [64:0] det;
        logic signed [52:0] p1;
        logic signed [52:0] p2;
        logic signed [52:0] d;
        logic               pos;
        det  = {pa[63], pa} - {pb[63], pb};
        pos  = !det[64] && (det != '0);
        p1   = -(emul(e.e1, 53'(m12)) + emul(e.e2, 53'(m22)));
        p2   = emul(e.e1, 53'(m11)) + emul(e.e2, 53'(m12));
        d    = emul(e.e1, p2) - emul(e.e2, p1);
        r.f.e1 = e.e1;
        r.f.e2 = e.e2;
        r.f.p1 = p1[33:0];
        r.f.p2 = p2[33:0];
        r.f.d  = d[34:0];
        r.bad  = !pos || (d == '0);
        // sqrt of 1 stands in for a nonpositive determinant; its result is discarded
        r.det  = pos ? det[63:0] : 64'd1;
        return r;
    endfunction

    assign en           = !r_v2 || i_cls_ready;
    assign i_edge.ready = en;
    assign o_cls_valid  = r_v2;
    assign o_cls        = r_cls;

    always_comb begin
        ea = face_edge(i_edge.data.first_tail_corner, i_edge.data.first_head_corner);
        eb = face_edge(i_edge.data.second_tail_corner, i_edge.data.second_head_corner);
        fa = face_calc(r_a11, r_a12, r_a22, r_ea, r_pa1, r_pb1);
        fb = face_calc(r_b11, r_b12, r_b22, r_eb, r_pa2, r_pb2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_edge.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a11 <= i_edge.data.first_m11;
            r_a12 <= i_edge.data.first_m12;
            r_a22 <= i_edge.data.first_m22;
            r_b11 <= i_edge.data.second_m11;
            r_b12 <= i_edge.data.second_m12;
            r_b22 <= i_edge.data.second_m22;
            r_pa1 <= i_edge.data.first_m11 * i_edge.data.first_m22;
            r_pb1 <= i_edge.data.first_m12 * i_edge.data.first_m12;
            r_pa2 <= i_edge.data.second_m11 * i_edge.data.second_m22;
            r_pb2 <= i_edge.data.second_m12 * i_edge.data.second_m12;
            r_ea  <= ea;
            r_eb  <= eb;
            r_bnd <= i_edge.data.on_boundary;
            r_cls.c.f1       <= fa.f;
            r_cls.c.f2       <= fb.f;
            r_cls.c.boundary <= r_bnd;
            r_cls.c.bad      <= fa.bad || fb.bad;
            r_cls.det1       <= fa.det;
            r_cls.det2       <= fb.det;
        end
    end

endmodule

@@ hw/rtl/etm_queue.sv @@
`timescale 1ns / 1ps
module etm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  etm_pkg::t_cls i_push_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output etm_pkg::t_cls o_pop_data
);
    import etm_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_cls          r_mem [0:QUEUE_DEPTH-1];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [AW:0]   r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != (AW + 1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

@@ hw/rtl/etm_back.sv @@
`timescale 1ns / 1ps
module etm_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cls_valid,
    output logic          o_cls_ready,
    input  etm_pkg::t_cls i_cls,
    etm_out_if.source     o_res
);
    import etm_pkg::*;

    typedef struct packed {
        logic boundary;
        logic bad;
    } t_flags;

    logic                   en;
    logic                   pop;
    logic [BACK_DEPTH-1:0]  r_vld;

    // square roots of both metric determinants
    t_sq                    r_sq1 [0:SQ_STEPS];
    t_sq                    r_sq2 [0:SQ_STEPS];
    t_carry                 r_sqc [0:SQ_STEPS];

    // |p| * s products
    logic [63:0]            r_mp [0:3];
    logic                   r_mneg [0:3];
    logic [31:0]            r_ms1, r_ms2;
    t_carry                 r_mc;

    // scaled-vector division, lanes 0..1 forward, 2..3 backward
    t_sc_lane               r_sc [0:SC_STEPS][0:3];
    logic [33:0]            r_scd1 [0:SC_STEPS];
    logic [33:0]            r_scd2 [0:SC_STEPS];
    t_carry                 r_scc [0:SC_STEPS];

    logic signed [51:0]     r_x [0:3];
    t_carry                 r_xc;

    // numerators, lanes 0..3 forward, 4..7 backward
    logic [51:0]            r_na [0:7];
    logic                   r_nneg [0:7];
    logic [33:0]            r_nb1, r_nb2;
    t_flags                 r_nf;

    t_qd_lane               r_qd [0:QD_STEPS][0:7];
    logic [33:0]            r_qb1 [0:QD_STEPS];
    logic [33:0]            r_qb2 [0:QD_STEPS];
    t_flags                 r_qf [0:QD_STEPS];

    t_out_word              r_out;
    t_out_word              n_out;

    logic [32:0]            mag_p [0:3];
    t_sc_lane               sc_init [0:3];
    logic signed [52:0]     numer [0:7];
    logic [52:0]            nneg_v [0:7];
    logic [34:0]            dneg1, dneg2;
    t_qd_lane               qd_init [0:7];
    t_qres                  qr [0:7];
    logic                   sat_any;

    assign en          = !r_vld[BACK_DEPTH-1] || o_res.ready;
    assign o_cls_ready = en;
    assign pop         = i_cls_valid && en;
    assign o_res.valid = r_vld[BACK_DEPTH-1];
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[BACK_DEPTH-2:0], pop};
        end
    end

    always_comb begin
        mag_p[0] = pmag(r_sqc[SQ_STEPS].f2.p1);
        mag_p[1] = pmag(r_sqc[SQ_STEPS].f2.p2);
        mag_p[2] = pmag(r_sqc[SQ_STEPS].f1.p1);
        mag_p[3] = pmag(r_sqc[SQ_STEPS].f1.p2);
        for (int l = 0; l < 4; l++) begin
            sc_init[l].rem  = {21'b0, r_mp[l][63:51]};
            sc_init[l].word = r_mp[l][50:0];
            sc_init[l].neg  = r_mneg[l];
            sc_init[l].ovf  = (l < 2) ? (sc_init[l].rem >= {2'b0, r_ms2})
                                      : (sc_init[l].rem >= {2'b0, r_ms1});
        end
    end

    always_comb begin
        // forward: source face 1, destination face 2
        numer[0] = emul(r_xc.f2.e1, 53'(r_xc.f1.p2)) - emul(r_xc.f1.e2, 53'(r_x[0]));
        numer[1] = emul(r_xc.f1.e1, 53'(r_x[0])) - emul(r_xc.f2.e1, 53'(r_xc.f1.p1));
        numer[2] = emul(r_xc.f2.e2, 53'(r_xc.f1.p2)) - emul(r_xc.f1.e2, 53'(r_x[1]));
        numer[3] = emul(r_xc.f1.e1, 53'(r_x[1])) - emul(r_xc.f2.e2, 53'(r_xc.f1.p1));
        // backward: source face 2, destination face 1
        numer[4] = emul(r_xc.f1.e1, 53'(r_xc.f2.p2)) - emul(r_xc.f2.e2, 53'(r_x[2]));
        numer[5] = emul(r_xc.f2.e1, 53'(r_x[2])) - emul(r_xc.f1.e1, 53'(r_xc.f2.p1));
        numer[6] = emul(r_xc.f1.e2, 53'(r_xc.f2.p2)) - emul(r_xc.f2.e2, 53'(r_x[3]));
        numer[7] = emul(r_xc.f2.e1, 53'(r_x[3])) - emul(r_xc.f1.e2, 53'(r_xc.f2.p1));
        for (int l = 0; l < 8; l++) begin
            nneg_v[l] = -numer[l];
        end
        dneg1 = -r_xc.f1.d;
        dneg2 = -r_xc.f2.d;
    end

    always_comb begin
        for (int l = 0; l < 8; l++) begin
            qd_init[l].rem  = r_na[l][51:18];
            qd_init[l].word = {r_na[l][17:0], 16'b0};
            qd_init[l].neg  = r_nneg[l];
            qd_init[l].ovf  = (l < 4) ? (qd_init[l].rem >= r_nb1) : (qd_init[l].rem >= r_nb2);
        end
    end

    always_comb begin
        sat_any = 1'b0;
        for (int l = 0; l < 8; l++) begin
            qr[l]   = q_final(r_qd[QD_STEPS][l]);
            sat_any = sat_any | qr[l].sat;
        end
        n_out = '0;
        priority if (r_qf[QD_STEPS].boundary) begin
            n_out.status = ST_BOUNDARY;
        end else if (r_qf[QD_STEPS].bad) begin
            n_out.status = ST_DEGEN;
        end else begin
            n_out.fwd_t11  = qr[0].val;
            n_out.fwd_t12  = qr[1].val;
            n_out.fwd_t21  = qr[2].val;
            n_out.fwd_t22  = qr[3].val;
            n_out.back_t11 = qr[4].val;
            n_out.back_t12 = qr[5].val;
            n_out.back_t21 = qr[6].val;
            n_out.back_t22 = qr[7].val;
            n_out.status   = sat_any ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq1[0] <= '{v: i_cls.det1, res: 64'd0};
            r_sq2[0] <= '{v: i_cls.det2, res: 64'd0};
            r_sqc[0] <= i_cls.c;
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_sq1[k+1] <= sqrt_step(r_sq1[k], k);
                r_sq2[k+1] <= sqrt_step(r_sq2[k], k);
                r_sqc[k+1] <= r_sqc[k];
            end

            r_ms1 <= r_sq1[SQ_STEPS].res[31:0];
            r_ms2 <= r_sq2[SQ_STEPS].res[31:0];
            r_mp[0] <= 64'(mag_p[0] * r_sq1[SQ_STEPS].res[31:0]);
            r_mp[1] <= 64'(mag_p[1] * r_sq1[SQ_STEPS].res[31:0]);
            r_mp[2] <= 64'(mag_p[2] * r_sq2[SQ_STEPS].res[31:0]);
            r_mp[3] <= 64'(mag_p[3] * r_sq2[SQ_STEPS].res[31:0]);
            r_mneg[0] <= r_sqc[SQ_STEPS].f2.p1[33];
            r_mneg[1] <= r_sqc[SQ_STEPS].f2.p2[33];
            r_mneg[2] <= r_sqc[SQ_STEPS].f1.p1[33];
            r_mneg[3] <= r_sqc[SQ_STEPS].f1.p2[33];
            r_mc <= r_sqc[SQ_STEPS];

            for (int l = 0; l < 4; l++) begin
                r_sc[0][l] <= sc_init[l];
            end
            r_scd1[0] <= {2'b0, r_ms2};
            r_scd2[0] <= {2'b0, r_ms1};
            r_scc[0]  <= r_mc;
            for (int k = 0; k < SC_STEPS; k++) begin
                r_sc[k+1][0] <= sc_next(r_sc[k][0], r_scd1[k]);
                r_sc[k+1][1] <= sc_next(r_sc[k][1], r_scd1[k]);
                r_sc[k+1][2] <= sc_next(r_sc[k][2], r_scd2[k]);
                r_sc[k+1][3] <= sc_next(r_sc[k][3], r_scd2[k]);
                r_scd1[k+1]  <= r_scd1[k];
                r_scd2[k+1]  <= r_scd2[k];
                r_scc[k+1]   <= r_scc[k];
            end

            for (int l = 0; l < 4; l++) begin
                r_x[l] <= x_of(r_sc[SC_STEPS][l]);
            end
            r_xc <= r_scc[SC_STEPS];

            for (int l = 0; l < 8; l++) begin
                r_na[l]   <= numer[l][52] ? nneg_v[l][51:0] : numer[l][51:0];
                r_nneg[l] <= numer[l][52] ^ ((l < 4) ? r_xc.f1.d[34] : r_xc.f2.d[34]);
            end
            r_nb1 <= r_xc.f1.d[34] ? dneg1[33:0] : r_xc.f1.d[33:0];
            r_nb2 <= r_xc.f2.d[34] ? dneg2[33:0] : r_xc.f2.d[33:0];
            r_nf  <= '{boundary: r_xc.boundary, bad: r_xc.bad};

            for (int l = 0; l < 8; l++) begin
                r_qd[0][l] <= qd_init[l];
            end
            r_qb1[0] <= r_nb1;
            r_qb2[0] <= r_nb2;
            r_qf[0]  <= r_nf;
            for (int k = 0; k < QD_STEPS; k++) begin
                for (int l = 0; l < 8; l++) begin
                    r_qd[k+1][l] <= qd_next(r_qd[k][l], (l < 4) ? r_qb1[k] : r_qb2[k]);
                end
                r_qb1[k+1] <= r_qb1[k];
                r_qb2[k+1] <= r_qb2[k];
                r_qf[k+1]  <= r_qf[k];
            end

            r_out <= n_out;
        end
    end

endmodule

@@ hw/rtl/edge_transport_matrix_top.sv @@
`timescale 1ns / 1ps
// Edge transport matrices: one mesh edge word in, one word of forward and backward 2x2
// Q16.16 transport matrices plus status out. The block is fully pipelined and takes one
// edge word every clock unless output back-pressure stalls it; the back end's datapath
// computes one bit per stage, with 32 stages of square root on the metric
// determinants, 51 stages of restoring division for the scaled vectors and 34 stages
// for the matrix entries. A four-word queue between the front end (corner decode,
// determinant and basis products) and the back end absorbs output stalls. Boundary and
// degenerate edges flow through the same pipeline and come out with zero matrices.
module edge_transport_matrix_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    etm_in_if.sink    i_edge,
    etm_out_if.source o_res
);
    import etm_pkg::*;

    t_cls front_cls;
    logic front_valid;
    logic front_ready;
    t_cls queue_cls;
    logic queue_valid;
    logic back_ready;

    etm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_edge      (i_edge),
        .o_cls       (front_cls),
        .o_cls_valid (front_valid),
        .i_cls_ready (front_ready)
    );

    etm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_cls),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (back_ready),
        .o_pop_data   (queue_cls)
    );

    etm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (queue_valid),
        .o_cls_ready (back_ready),
        .i_cls       (queue_cls),
        .o_res       (o_res)
    );

endmodule

@@ hw/rtl/etm_checker.sv @@
`timescale 1ns / 1ps
module etm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input etm_pkg::t_out_word i_out_data
);
    import etm_pkg::*;

    logic mat_zero;

    assign mat_zero = (i_out_data.fwd_t11 == '0) && (i_out_data.fwd_t12 == '0) &&
                      (i_out_data.fwd_t21 == '0) && (i_out_data.fwd_t22 == '0) &&
                      (i_out_data.back_t11 == '0) && (i_out_data.back_t12 == '0) &&
                      (i_out_data.back_t21 == '0) && (i_out_data.back_t22 == '0);

    a_boundary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_data.status == ST_BOUNDARY)) |-> mat_zero)
        else $error("boundary word carries nonzero matrix");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_data.status == ST_DEGEN)) |-> mat_zero)
        else $error("degenerate word carries nonzero matrix");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled output word changed");

endmodule

bind edge_transport_matrix_top etm_checker u_etm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

@@ tb/edge_transport_matrix_top_tb.sv @@
`timescale 1ns / 1ps
module edge_transport_matrix_top_tb;
    import etm_pkg::*;

    localparam int N_RANDOM = 1830;
    localparam int LAT_WAIT = 300;

    logic i_clk;
    logic i_rst_n;

    etm_in_if  edge_ch ();
    etm_out_if res_ch ();

    edge_transport_matrix_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_edge  (edge_ch.sink),
        .o_res   (res_ch.source)
    );

    typedef struct {
        longint          e1;
        longint          e2;
        longint          p1;
        longint          p2;
        longint          d;
        longint unsigned s;
        bit              bad;
    } t_face_geom;

    class transport_scoreboard;
        t_out_word expected_q[$];
        int        n_errors;
        int        n_checked;
        int        n_status[4];

        task report(string what, t_out_word got, t_out_word want);
            n_errors++;
            if (n_errors <= 20)
                $display("MISMATCH %s: got %h want %h", what, got, want);
        endtask

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned tr;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                tr = r | (64'd1 << b);
                if (tr * tr <= v)
                    r = tr;
            end
            return r;
        endfunction

        function t_face_geom build_face(logic signed [31:0] a11, logic signed [31:0] a12,
                                        logic signed [31:0] a22, logic [1:0] t,
                                        logic [1:0] h);
            t_face_geom f;
            longint     det;
            f.e1 = 0;
            f.e2 = 0;
            // corner 0 is the origin; corner 3 contributes nothing
            if (t == 2'd1) f.e1 -= 1;
            else if (h == 2'd1) f.e1 += 1;
            if (t == 2'd2) f.e2 -= 1;
            else if (h == 2'd2) f.e2 += 1;
            f.p1 = -longint'(a12) * f.e1 - longint'(a22) * f.e2;
            f.p2 = longint'(a11) * f.e1 + longint'(a12) * f.e2;
            det  = longint'(a11) * longint'(a22) - longint'(a12) * longint'(a12);
            f.d  = f.e1 * f.p2 - f.e2 * f.p1;
            f.bad = (det <= 0) || (f.d == 0);
            f.s  = (det > 0) ? root_floor(longint'(det)) : 1;
            return f;
        endfunction

        function longint rescale(longint v, longint unsigned sn, longint unsigned sd);
            logic [127:0] m;
            longint       r;
            m = (128'(v < 0 ? -v : v) * 128'(sn)) / 128'(sd);
            r = (m > (128'd1 << 50)) ? (longint'(1) << 50) : longint'(m[63:0]);
            return v < 0 ? -r : r;
        endfunction

        function logic [31:0] q16_div(longint n, longint d, inout bit sat);
            longint unsigned a;
            longint unsigned b;
            longint unsigned m;
            longint          r;
            a = n < 0 ? -n : n;
            b = d < 0 ? -d : d;
            if (a / b > (64'd1 << 16))
                m = 64'd1 << 40;
            else
                m = ((a / b) << 16) + ((a % b) << 16) / b;
            if ((n < 0) != (d < 0)) begin
                if (m > 64'h80000000) begin
                    sat = 1'b1;
                    m = 64'h80000000;
                end
                r = -longint'(m);
            end else begin
                if (m > 64'h7FFFFFFF) begin
                    sat = 1'b1;
                    m = 64'h7FFFFFFF;
                end
                r = longint'(m);
            end
            return r[31:0];
        endfunction

        function void carry_across(t_face_geom src, t_face_geom dst, inout bit sat,
                                   output logic [31:0] t11, output logic [31:0] t12,
                                   output logic [31:0] t21, output logic [31:0] t22);
            longint x1;
            longint x2;
            x1  = rescale(dst.p1, src.s, dst.s);
            x2  = rescale(dst.p2, src.s, dst.s);
            t11 = q16_div(dst.e1 * src.p2 - src.e2 * x1, src.d, sat);
            t12 = q16_div(src.e1 * x1 - dst.e1 * src.p1, src.d, sat);
            t21 = q16_div(dst.e2 * src.p2 - src.e2 * x2, src.d, sat);
            t22 = q16_div(src.e1 * x2 - dst.e2 * src.p1, src.d, sat);
        endfunction

        function void note_edge(t_in_word w);
            t_out_word  r;
            t_face_geom f1;
            t_face_geom f2;
            bit         sat;
            r   = '0;
            sat = 1'b0;
            if (w.on_boundary) begin
                r.status = ST_BOUNDARY;
            end else begin
                f1 = build_face(w.first_m11, w.first_m12, w.first_m22,
                                w.first_tail_corner, w.first_head_corner);
                f2 = build_face(w.second_m11, w.second_m12, w.second_m22,
                                w.second_tail_corner, w.second_head_corner);
                if (f1.bad || f2.bad) begin
                    r.status = ST_DEGEN;
                end else begin
                    carry_across(f1, f2, sat, r.fwd_t11, r.fwd_t12, r.fwd_t21, r.fwd_t22);
                    carry_across(f2, f1, sat, r.back_t11, r.back_t12, r.back_t21,
                                 r.back_t22);
                    r.status = sat ? ST_SAT : ST_OK;
                end
            end
            expected_q.push_back(r);
        endfunction

        task check_result(t_out_word got);
            t_out_word want;
            if (expected_q.size() == 0) begin
                report("unexpected word", got, '0);
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            n_status[want.status]++;
            if (got.fwd_t11 !== want.fwd_t11) report("fwd_t11", got, want);
            if (got.fwd_t12 !== want.fwd_t12) report("fwd_t12", got, want);
            if (got.fwd_t21 !== want.fwd_t21) report("fwd_t21", got, want);
            if (got.fwd_t22 !== want.fwd_t22) report("fwd_t22", got, want);
            if (got.back_t11 !== want.back_t11) report("back_t11", got, want);
            if (got.back_t12 !== want.back_t12) report("back_t12", got, want);
            if (got.back_t21 !== want.back_t21) report("back_t21", got, want);
            if (got.back_t22 !== want.back_t22) report("back_t22", got, want);
            if (got.status !== want.status) report("status", got, want);
        endtask
    endclass

    transport_scoreboard sb = new();

    int burst_left;
    int cycle_cnt;
    int stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: ready follows one of four stall modes, redrawn at random at regular intervals
    initial res_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 256 == 0)
            stall_mode <= $urandom_range(0, 3);
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.data);
        case (stall_mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= ($urandom_range(0, 1) == 1);
            2: res_ch.ready <= ($urandom_range(0, 7) == 0);
            default: res_ch.ready <= (cycle_cnt % 5 != 0);
        endcase
    end

    task automatic send_edge(t_in_word w);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                edge_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        edge_ch.valid <= 1'b1;
        edge_ch.data  <= w;
        do @(posedge i_clk); while (!edge_ch.ready);
        sb.note_edge(w);
    endtask

    function automatic logic signed [31:0] rand_pos();
        logic [31:0] v;
        v = $urandom_range(1, 32'h7FFFFFFF) >> $urandom_range(0, 30);
        return (v == 0) ? 32'sd1 : $signed(v);
    endfunction

    function automatic t_in_word well_formed_edge();
        t_in_word w;
        logic signed [31:0] lim;
        w = '0;
        w.first_m11  = rand_pos();
        w.first_m22  = rand_pos();
        lim = (w.first_m11 < w.first_m22) ? w.first_m11 : w.first_m22;
        w.first_m12  = $signed($urandom % lim) * ($urandom_range(0, 1) ? 1 : -1);
        w.second_m11 = rand_pos();
        w.second_m22 = rand_pos();
        lim = (w.second_m11 < w.second_m22) ? w.second_m11 : w.second_m22;
        w.second_m12 = $signed($urandom % lim) * ($urandom_range(0, 1) ? 1 : -1);
        w.first_tail_corner  = 2'($urandom_range(0, 2));
        w.first_head_corner  = 2'((w.first_tail_corner + $urandom_range(1, 2)) % 3);
        w.second_tail_corner = 2'($urandom_range(0, 2));
        w.second_head_corner = 2'((w.second_tail_corner + $urandom_range(1, 2)) % 3);
        return w;
    endfunction

    function automatic t_in_word noise_edge();
        t_in_word w;
        w.first_m11  = $urandom;
        w.first_m12  = $urandom;
        w.first_m22  = $urandom;
        w.second_m11 = $urandom;
        w.second_m12 = $urandom;
        w.second_m22 = $urandom;
        w.first_tail_corner  = 2'($urandom_range(0, 3));
        w.first_head_corner  = 2'($urandom_range(0, 3));
        w.second_tail_corner = 2'($urandom_range(0, 3));
        w.second_head_corner = 2'($urandom_range(0, 3));
        w.on_boundary = 1'($urandom_range(0, 1));
        return w;
    endfunction

    initial begin
        t_in_word w;
        int       pick;
        i_rst_n       = 1'b0;
        edge_ch.valid = 1'b0;
        edge_ch.data  = '0;
        burst_left    = 0;
        cycle_cnt     = 0;
        stall_mode    = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: unit metrics, corner permutations
        w = '0;
        w.first_m11 = 32'sh10000; w.first_m22 = 32'sh10000;
        w.second_m11 = 32'sh10000; w.second_m22 = 32'sh10000;
        for (int t = 0; t < 3; t++) begin
            w.first_tail_corner = 2'(t); w.first_head_corner = 2'((t + 1) % 3);
            w.second_tail_corner = 2'((t + 2) % 3); w.second_head_corner = 2'(t);
            send_edge(w);
        end
        w.on_boundary = 1'b1;
        send_edge(w);
        w.on_boundary = 1'b0;
        // bad corner code and equal corners
        w.first_tail_corner = 2'd3; send_edge(w);
        w.first_tail_corner = 2'd1; w.first_head_corner = 2'd3; send_edge(w);
        w.first_head_corner = 2'd1; send_edge(w);
        w.first_tail_corner = 2'd0; w.first_head_corner = 2'd0; send_edge(w);
        w.first_tail_corner = 2'd2; w.first_head_corner = 2'd2; send_edge(w);
        w.first_tail_corner = 2'd3; w.first_head_corner = 2'd3; send_edge(w);
        w.first_tail_corner = 2'd0; w.first_head_corner = 2'd1;
        // nonpositive determinants
        w.second_m12 = 32'sh10000; send_edge(w);
        w.second_m11 = -32'sh10000; w.second_m12 = '0; send_edge(w);
        // extremes: largest and smallest metrics, scale mismatch
        w.second_m11 = 32'sh7FFFFFFF; w.second_m22 = 32'sh7FFFFFFF;
        w.second_m12 = 32'sh7FFFFFFE; send_edge(w);
        w.second_m12 = -32'sh80000000; send_edge(w);
        w.second_m12 = '0; w.first_m11 = 32'sd1; w.first_m22 = 32'sd1; send_edge(w);
        w.first_m11 = 32'sh7FFFFFFF; w.first_m22 = 32'sd1; send_edge(w);
        w.second_m11 = -32'sh80000000; w.second_m22 = -32'sh80000000; send_edge(w);
        w.first_m11 = 32'sd1; w.first_m22 = 32'sh7FFFFFFF; w.second_m11 = 32'sh7FFFFFFF;
        w.second_m22 = 32'sd3; w.second_tail_corner = 2'd1; w.second_head_corner = 2'd2;
        send_edge(w);
        w = '1; send_edge(w);
        w.on_boundary = 1'b0; send_edge(w);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                // drain the pipe once with input held off
                edge_ch.valid <= 1'b0;
                while (sb.expected_q.size() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 72) w = well_formed_edge();
            else if (pick < 80) begin
                w = noise_edge(); w.on_boundary = 1'b1;
            end else w = noise_edge();
            send_edge(w);
        end
        edge_ch.valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (LAT_WAIT) @(posedge i_clk);
        $display("checked %0d result words: %0d ok, %0d boundary, %0d degenerate, %0d saturated",
                 sb.n_checked, sb.n_status[0], sb.n_status[1], sb.n_status[2],
                 sb.n_status[3]);
        $display("sender bursts with gaps and a full drain; receiver stall modes rotated");
        if (sb.n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
